### src/bir_pkg.sv
// Shared types and constants for the bilinear image resize block.
`timescale 1ns / 1ps

package bir_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 9;
    localparam int STEP_W    = 24;
    localparam int STEP_FRAC = 16;
    localparam int POS_W     = COORD_W + STEP_W;
    localparam int IP_W      = POS_W - STEP_FRAC;
    localparam int SIZE_W    = 2 * DIM_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;

    localparam logic OP_LOAD       = 1'b0;
    localparam logic MODE_BILINEAR = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ZERO,
        CMD_INTERP
    } t_kind;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_CLAMP,
        F_ROWM,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_LAST,
        B_OUT
    } t_bstate;

    typedef struct packed {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [STEP_W-1:0] row_step;
        logic [STEP_W-1:0] col_step;
        logic              mode;
    } t_cfg;

endpackage

### src/bir_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bir_fifo.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module bir_fifo #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam logic [1:0] FULL_CNT = 2'd2;

    T           r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[r_rp];

endmodule

### src/bir_front.sv
// Front end: accepts items, maps targets to source neighbours and weights, queues commands.
`timescale 1ns / 1ps

module bir_front #(
    parameter int  MAX_DIM   = 256,
    parameter int  FRAC_BITS = 8,
    parameter type T         = logic
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bir_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_opcode,
    input  logic [bir_pkg::PIX_W-1:0]     i_pixel_in,
    input  logic [bir_pkg::COORD_W-1:0]   i_out_row,
    input  logic [bir_pkg::COORD_W-1:0]   i_out_col,
    output logic                          o_push,
    output T                              o_cmd,
    input  logic                          i_full
);

    localparam int AW      = $clog2(MAX_DIM * MAX_DIM);
    localparam int WW      = 2 * FRAC_BITS + 1;
    localparam int OW      = FRAC_BITS + 1;
    localparam int PW      = 2 * OW;
    localparam int CW      = (AW + 1 > bir_pkg::SIZE_W) ? AW + 1 : bir_pkg::SIZE_W;
    localparam int DIM_MAX = (1 << bir_pkg::DIM_W) - 1;
    localparam int DIM_CAP = (MAX_DIM > DIM_MAX) ? DIM_MAX : MAX_DIM;

    localparam logic [bir_pkg::DIM_W-1:0] CAP = bir_pkg::DIM_W'(DIM_CAP);
    localparam logic [OW-1:0]             ONE = OW'(1) << FRAC_BITS;

    bir_pkg::t_fstate r_state;
    bir_pkg::t_fstate n_state;

    logic                           r_op;
    logic [bir_pkg::PIX_W-1:0]      r_pix;
    logic [bir_pkg::COORD_W-1:0]    r_row;
    logic [bir_pkg::COORD_W-1:0]    r_col;
    logic [bir_pkg::POS_W-1:0]      r_pos_r;
    logic [bir_pkg::POS_W-1:0]      r_pos_c;
    logic [bir_pkg::SIZE_W-1:0]     r_size;
    logic [bir_pkg::DIM_W-1:0]      r_r0;
    logic [bir_pkg::DIM_W-1:0]      r_r1;
    logic [bir_pkg::DIM_W-1:0]      r_c0;
    logic [bir_pkg::DIM_W-1:0]      r_c1;
    logic [FRAC_BITS-1:0]           r_fr;
    logic [FRAC_BITS-1:0]           r_fc;
    logic [bir_pkg::SIZE_W-1:0]     r_rb0;
    logic [bir_pkg::SIZE_W-1:0]     r_rb1;
    logic [3:0][WW-1:0]             r_w;
    logic [AW-1:0]                  r_ptr;
    logic [AW-1:0]                  r_laddr;
    bir_pkg::t_kind                 r_kind;

    logic                           accept;
    logic [bir_pkg::DIM_W-1:0]      rows_e;
    logic [bir_pkg::DIM_W-1:0]      cols_e;
    logic [bir_pkg::DIM_W-1:0]      base_r;
    logic [bir_pkg::DIM_W-1:0]      base_c;
    logic [CW-1:0]                  ld_addr;
    logic [CW-1:0]                  ld_next;
    logic [OW-1:0]                  om_r;
    logic [OW-1:0]                  om_c;

    function automatic logic [bir_pkg::DIM_W-1:0] clamp_base(
        input logic [bir_pkg::POS_W-1:0] pos,
        input logic [bir_pkg::DIM_W-1:0] last
    );
        logic [bir_pkg::IP_W-1:0] ip;
        ip = pos[bir_pkg::POS_W-1:bir_pkg::STEP_FRAC];
        return (ip > bir_pkg::IP_W'(last)) ? last : ip[bir_pkg::DIM_W-1:0];
    endfunction

    function automatic logic [bir_pkg::DIM_W-1:0] eff_dim(
        input logic [bir_pkg::DIM_W-1:0] v
    );
        if (v == '0) begin
            return bir_pkg::DIM_W'(1);
        end
        return (v > CAP) ? CAP : v;
    endfunction

    assign rows_e = eff_dim(i_cfg.rows);
    assign cols_e = eff_dim(i_cfg.cols);
    assign base_r = clamp_base(r_pos_r, rows_e - bir_pkg::DIM_W'(1));
    assign base_c = clamp_base(r_pos_c, cols_e - bir_pkg::DIM_W'(1));

    assign ld_addr = (CW'(r_ptr) < CW'(r_size)) ? CW'(r_ptr) : '0;
    assign ld_next = ld_addr + CW'(1);

    assign om_r = ONE - OW'(r_fr);
    assign om_c = ONE - OW'(r_fc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bir_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            bir_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = bir_pkg::F_MUL;
                end
            end
            bir_pkg::F_MUL: begin
                n_state = bir_pkg::F_CLAMP;
            end
            bir_pkg::F_CLAMP: begin
                if (r_op == bir_pkg::OP_LOAD || i_cfg.mode != bir_pkg::MODE_BILINEAR) begin
                    n_state = bir_pkg::F_PUSH;
                end else begin
                    n_state = bir_pkg::F_ROWM;
                end
            end
            bir_pkg::F_ROWM: begin
                n_state = bir_pkg::F_PUSH;
            end
            bir_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    o_ready = 1'b1;
                    n_state = i_valid ? bir_pkg::F_MUL : bir_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = bir_pkg::F_IDLE;
            end
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (r_state == bir_pkg::F_CLAMP && r_op == bir_pkg::OP_LOAD) begin
            r_ptr <= (ld_next >= CW'(r_size)) ? '0 : AW'(ld_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_pix <= i_pixel_in;
            r_row <= i_out_row;
            r_col <= i_out_col;
        end
        case (r_state)
            bir_pkg::F_MUL: begin
                r_pos_r <= bir_pkg::POS_W'(r_row) * bir_pkg::POS_W'(i_cfg.row_step);
                r_pos_c <= bir_pkg::POS_W'(r_col) * bir_pkg::POS_W'(i_cfg.col_step);
                r_size  <= bir_pkg::SIZE_W'(rows_e) * bir_pkg::SIZE_W'(cols_e);
            end
            bir_pkg::F_CLAMP: begin
                r_r0    <= base_r;
                r_r1    <= (base_r == rows_e - bir_pkg::DIM_W'(1)) ?
                           base_r : base_r + bir_pkg::DIM_W'(1);
                r_c0    <= base_c;
                r_c1    <= (base_c == cols_e - bir_pkg::DIM_W'(1)) ?
                           base_c : base_c + bir_pkg::DIM_W'(1);
                r_fr    <= r_pos_r[bir_pkg::STEP_FRAC-1 -: FRAC_BITS];
                r_fc    <= r_pos_c[bir_pkg::STEP_FRAC-1 -: FRAC_BITS];
                r_laddr <= AW'(ld_addr);
                if (r_op == bir_pkg::OP_LOAD) begin
                    r_kind <= bir_pkg::CMD_LOAD;
                end else if (i_cfg.mode != bir_pkg::MODE_BILINEAR) begin
                    r_kind <= bir_pkg::CMD_ZERO;
                end else begin
                    r_kind <= bir_pkg::CMD_INTERP;
                end
            end
            bir_pkg::F_ROWM: begin
                r_rb0  <= bir_pkg::SIZE_W'(r_r0) * bir_pkg::SIZE_W'(cols_e);
                r_rb1  <= bir_pkg::SIZE_W'(r_r1) * bir_pkg::SIZE_W'(cols_e);
                r_w[0] <= WW'(PW'(om_r) * PW'(om_c));
                r_w[1] <= WW'(PW'(om_r) * PW'(r_fc));
                r_w[2] <= WW'(PW'(r_fr) * PW'(om_c));
                r_w[3] <= WW'(PW'(r_fr) * PW'(r_fc));
            end
            default: begin
            end
        endcase
    end

    // neighbour order: north-west, north-east, south-west, south-east
    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        o_cmd.pix  = r_pix;
        if (r_kind == bir_pkg::CMD_LOAD) begin
            o_cmd.addr[0] = r_laddr;
        end else begin
            o_cmd.addr[0] = AW'(r_rb0 + bir_pkg::SIZE_W'(r_c0));
            o_cmd.addr[1] = AW'(r_rb0 + bir_pkg::SIZE_W'(r_c1));
            o_cmd.addr[2] = AW'(r_rb1 + bir_pkg::SIZE_W'(r_c0));
            o_cmd.addr[3] = AW'(r_rb1 + bir_pkg::SIZE_W'(r_c1));
            o_cmd.wgt     = r_w;
        end
    end

endmodule

### src/bir_back.sv
// Back end: owns the image memory, runs loads and the four-tap weighted sum.
`timescale 1ns / 1ps

module bir_back #(
    parameter int  MAX_DIM   = 256,
    parameter int  FRAC_BITS = 8,
    parameter type T         = logic
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  T                          i_cmd,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [bir_pkg::PIX_W-1:0] o_pixel_out
);

    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int ACC_W = 2 * FRAC_BITS + bir_pkg::PIX_W;

    bir_pkg::t_bstate r_state;
    bir_pkg::t_bstate n_state;

    logic [1:0]                r_k;
    logic [1:0]                n_k;
    logic [ACC_W-1:0]          r_acc;
    logic [ACC_W-1:0]          n_acc;
    logic                      r_out_valid;
    logic [bir_pkg::PIX_W-1:0] r_out_pix;

    logic                      out_free;
    logic                      load_out;
    logic [bir_pkg::PIX_W-1:0] out_val;
    logic [1:0]                widx;
    logic [ACC_W-1:0]          sum;
    logic                      mem_we;
    logic [AW-1:0]             mem_addr;
    logic [bir_pkg::PIX_W-1:0] mem_rdata;

    bir_ram #(
        .WIDTH (bir_pkg::PIX_W),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_cmd.pix),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_out_valid || i_ready;
    // read data arrives in the cycle after its address, so it pairs with the previous weight
    assign widx     = r_k - 2'd1;
    assign sum      = r_acc + ACC_W'(mem_rdata) * ACC_W'(i_cmd.wgt[widx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bir_pkg::B_IDLE;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (load_out) begin
            r_out_pix <= out_val;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_acc    = r_acc;
        mem_we   = 1'b0;
        mem_addr = i_cmd.addr[0];
        o_pop    = 1'b0;
        load_out = 1'b0;
        out_val  = r_acc[ACC_W-1 -: bir_pkg::PIX_W];
        case (r_state)
            bir_pkg::B_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.kind)
                        bir_pkg::CMD_LOAD: begin
                            mem_we = 1'b1;
                            o_pop  = 1'b1;
                        end
                        bir_pkg::CMD_ZERO: begin
                            if (out_free) begin
                                load_out = 1'b1;
                                out_val  = '0;
                                o_pop    = 1'b1;
                            end
                        end
                        bir_pkg::CMD_INTERP: begin
                            n_k     = 2'd1;
                            n_acc   = '0;
                            n_state = bir_pkg::B_READ;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            bir_pkg::B_READ: begin
                mem_addr = i_cmd.addr[r_k];
                n_acc    = sum;
                n_k      = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = bir_pkg::B_LAST;
                end
            end
            bir_pkg::B_LAST: begin
                n_acc = sum;
                if (out_free) begin
                    load_out = 1'b1;
                    out_val  = sum[ACC_W-1 -: bir_pkg::PIX_W];
                    o_pop    = 1'b1;
                    n_state  = bir_pkg::B_IDLE;
                end else begin
                    n_state = bir_pkg::B_OUT;
                end
            end
            bir_pkg::B_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    o_pop    = 1'b1;
                    n_state  = bir_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = bir_pkg::B_IDLE;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pix;

endmodule

### src/bilinear_image_resize.sv
// Top level of the grayscale bilinear image resize block.
//
// Input channel (i_valid/o_ready): opcode 0 loads the next source pixel in raster
// order; the write pointer wraps after rows*cols pixels. Opcode 1 requests one
// target pixel at (i_out_row, i_out_col) and produces exactly one o_pixel_out
// transfer on the output channel (o_valid/i_ready). Loads produce nothing.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// The front end steps through multiply, clamp and push states, adding a row-multiply
// state for a bilinear request, and can take the next item while it pushes the
// current one unless the queue is full; the back end handles a load or zero-mode
// request in its idle state and reads the four neighbours of a bilinear request
// through the single image memory port, one by one, before the final add.
// A two-entry command queue lets either side run ahead of the other.
// Reset clears the control state and the load pointer and resets the configuration; the
// image memory is not cleared, so the source image must be loaded before use.
// A result waits in the output register while i_ready is low; the back end then
// holds, the queue fills and o_ready drops until results drain.
`timescale 1ns / 1ps

module bilinear_image_resize #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bir_pkg::STEP_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_opcode,
    input  logic [bir_pkg::PIX_W-1:0]       i_pixel_in,
    input  logic [bir_pkg::COORD_W-1:0]     i_out_row,
    input  logic [bir_pkg::COORD_W-1:0]     i_out_col,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bir_pkg::PIX_W-1:0]       o_pixel_out
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int WW = 2 * FRAC_BITS + 1;

    typedef struct packed {
        bir_pkg::t_kind            kind;
        logic [bir_pkg::PIX_W-1:0] pix;
        logic [3:0][AW-1:0]        addr;
        logic [3:0][WW-1:0]        wgt;
    } t_cmd;

    bir_pkg::t_cfg r_cfg;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows     <= bir_pkg::DIM_W'(1);
            r_cfg.cols     <= bir_pkg::DIM_W'(1);
            r_cfg.row_step <= bir_pkg::STEP_W'(1) << bir_pkg::STEP_FRAC;
            r_cfg.col_step <= bir_pkg::STEP_W'(1) << bir_pkg::STEP_FRAC;
            r_cfg.mode     <= bir_pkg::MODE_BILINEAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bir_pkg::REG_ROWS:     r_cfg.rows     <= i_cfg_data[bir_pkg::DIM_W-1:0];
                bir_pkg::REG_COLS:     r_cfg.cols     <= i_cfg_data[bir_pkg::DIM_W-1:0];
                bir_pkg::REG_ROW_STEP: r_cfg.row_step <= i_cfg_data;
                bir_pkg::REG_COL_STEP: r_cfg.col_step <= i_cfg_data;
                bir_pkg::REG_MODE:     r_cfg.mode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bir_front #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .T         (t_cmd)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_opcode   (i_opcode),
        .i_pixel_in (i_pixel_in),
        .i_out_row  (i_out_row),
        .i_out_col  (i_out_col),
        .o_push     (push),
        .o_cmd      (cmd_in),
        .i_full     (full)
    );

    bir_fifo #(
        .T (t_cmd)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (cmd_out),
        .o_empty (empty)
    );

    bir_back #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .T         (t_cmd)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out)
    );

endmodule

### bench/testbench.sv
// Self-checking testbench for the bilinear image resize block.
`timescale 1ns / 1ps

module testbench;
    import bir_pkg::*;

    localparam int MAX_DIM       = 256;
    localparam int FRAC_BITS     = 8;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam longint unsigned WEIGHT_ONE = 1 << FRAC_BITS;

    localparam logic OP_REQUEST = 1'b1;
    localparam logic MODE_ZERO  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_pixel_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [STEP_W-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_opcode = OP_LOAD;
    logic [PIX_W-1:0]     i_pixel_in = '0;
    logic [COORD_W-1:0]   i_out_row = '0;
    logic [COORD_W-1:0]   i_out_col = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [PIX_W-1:0]     o_pixel_out;

    // mirror of the block state
    logic [PIX_W-1:0]  src_image [0:MAX_DIM*MAX_DIM-1];
    int                load_ptr = 0;
    logic [DIM_W-1:0]  cfg_rows = 1;
    logic [DIM_W-1:0]  cfg_cols = 1;
    logic [STEP_W-1:0] cfg_row_step = 24'h010000;
    logic [STEP_W-1:0] cfg_col_step = 24'h010000;
    logic              cfg_mode = MODE_BILINEAR;

    t_pixel_cmd       pixel_cmds[$];
    logic [PIX_W-1:0] expected_pixels[$];
    t_pixel_cmd       cur_cmd = '0;
    logic [PIX_W-1:0] want_pixel;
    bit               cmd_active = 1'b0;
    bit               cmd_taken = 1'b0;
    bit               send_idle_on = 1'b1;
    bit               recv_idle_on = 1'b1;
    int               send_gap = 0;
    int               take_gap = 0;
    int               queued_cnt = 0;
    int               accepted_cnt = 0;
    int               errors = 0;
    int               cycle_count = 0;

    bilinear_image_resize #(
        .MAX_DIM  (MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_opcode   (i_opcode),
        .i_pixel_in (i_pixel_in),
        .i_out_row  (i_out_row),
        .i_out_col  (i_out_col),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_pixel_out(o_pixel_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void locate_axis(input logic [COORD_W-1:0] target,
                                        input logic [STEP_W-1:0] step, input int dim,
                                        output int base, output int nxt, output int frac);
        logic [POS_W-1:0] pos;
        logic [IP_W-1:0]  ip;
        pos  = POS_W'(target) * POS_W'(step);
        ip   = pos[POS_W-1:STEP_FRAC];
        base = (ip > IP_W'(dim - 1)) ? dim - 1 : int'(ip);
        nxt  = (base + 1 > dim - 1) ? dim - 1 : base + 1;
        frac = int'(pos[STEP_FRAC-1 -: FRAC_BITS]);
    endfunction

    function automatic logic [PIX_W-1:0] resize_pixel(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col);
        int rows, cols, r0, r1, fr, c0, c1, fc;
        longint unsigned nw, ne, sw, se, acc;
        rows = eff_dim(cfg_rows);
        cols = eff_dim(cfg_cols);
        locate_axis(row, cfg_row_step, rows, r0, r1, fr);
        locate_axis(col, cfg_col_step, cols, c0, c1, fc);
        nw  = src_image[r0 * cols + c0];
        ne  = src_image[r0 * cols + c1];
        sw  = src_image[r1 * cols + c0];
        se  = src_image[r1 * cols + c1];
        acc = nw * (WEIGHT_ONE - fr) * (WEIGHT_ONE - fc)
            + ne * (WEIGHT_ONE - fr) * fc
            + sw * fr * (WEIGHT_ONE - fc)
            + se * fr * fc;
        return PIX_W'(acc >> (2 * FRAC_BITS));
    endfunction

    function automatic void absorb_cmd(input t_pixel_cmd cmd);
        int area, addr;
        if (cmd.opcode == OP_LOAD) begin
            area = eff_dim(cfg_rows) * eff_dim(cfg_cols);
            addr = (load_ptr < area) ? load_ptr : 0;
            src_image[addr] = cmd.pixel;
            addr++;
            load_ptr = (addr >= area) ? 0 : addr;
        end else if (cfg_mode != MODE_BILINEAR) begin
            expected_pixels.push_back('0);
        end else begin
            expected_pixels.push_back(resize_pixel(cmd.row, cmd.col));
        end
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_active = 1'b0;
            send_gap   = 0;
        end else begin
            if (cmd_taken) begin
                cmd_active = 1'b0;
                cmd_taken  = 1'b0;
            end
            if (!cmd_active) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pixel_cmds.size() > 0) begin
                    if (send_idle_on && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 11);
                    end else begin
                        cur_cmd    = pixel_cmds.pop_front();
                        cmd_active = 1'b1;
                    end
                end
            end
        end
        i_valid    <= cmd_active;
        i_opcode   <= cur_cmd.opcode;
        i_pixel_in <= cur_cmd.pixel;
        i_out_row  <= cur_cmd.row;
        i_out_col  <= cur_cmd.col;
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (take_gap > 0) begin
            take_gap--;
            i_ready <= 1'b0;
        end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
            take_gap = $urandom_range(0, 11);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor: check results first, then record the input transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out: expected nothing, got %0d", o_pixel_out);
                    errors++;
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    if (o_pixel_out !== want_pixel) begin
                        $error("pixel_out: expected %0d, got %0d", want_pixel, o_pixel_out);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                absorb_cmd(cur_cmd);
                cmd_taken = 1'b1;
                accepted_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_item(input logic op, input logic [PIX_W-1:0] pix,
                            input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
        pixel_cmds.push_back('{opcode: op, pixel: pix, row: row, col: col});
        queued_cnt++;
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || expected_pixels.size() != 0)
            @(negedge i_clk);
        // loads give no result and may still be in the back end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ROWS:     cfg_rows = data[DIM_W-1:0];
            REG_COLS:     cfg_cols = data[DIM_W-1:0];
            REG_ROW_STEP: cfg_row_step = data;
            REG_COL_STEP: cfg_col_step = data;
            REG_MODE:     cfg_mode = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                                input logic [STEP_W-1:0] rstep,
                                input logic [STEP_W-1:0] cstep, input logic mode);
        write_reg(REG_ROWS, STEP_W'(rows));
        write_reg(REG_COLS, STEP_W'(cols));
        write_reg(REG_ROW_STEP, rstep);
        write_reg(REG_COL_STEP, cstep);
        write_reg(REG_MODE, STEP_W'(mode));
        // unmapped index must be ignored
        write_reg(CFG_IDX_W'($urandom_range(REG_MODE + 1, (1 << CFG_IDX_W) - 1)),
                  STEP_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one full image from wherever the pointer stands covers every address
    task automatic load_image();
        int area;
        area = eff_dim(cfg_rows) * eff_dim(cfg_cols);
        repeat (area)
            add_item(OP_LOAD, PIX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    function automatic logic [COORD_W-1:0] rand_target(input logic [STEP_W-1:0] step,
                                                      input int dim);
        longint lim;
        if (step == 0 || $urandom_range(0, 3) == 0) return COORD_W'($urandom_range(0, COORD_MAX));
        lim = ((longint'(dim) + 1) << STEP_FRAC) / step;
        if (lim > COORD_MAX) lim = COORD_MAX;
        return COORD_W'($urandom_range(0, int'(lim)));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return DIM_W'(MAX_DIM);
            1:       return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
            2:       return '0;
            default: return DIM_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 24'h010000;
            3:       return STEP_W'($urandom);
            default: return STEP_W'($urandom_range(24'h002000, 24'h030000));
        endcase
    endfunction

    task automatic random_phase(input int n_items, input bit calm);
        logic [DIM_W-1:0] rows, cols;
        logic [STEP_W-1:0] rstep, cstep;
        logic mode;
        rows  = pick_dim();
        cols  = pick_dim();
        // large images only as single-row or single-column strips
        if (eff_dim(rows) * eff_dim(cols) > 64) begin
            if ($urandom_range(0, 1) == 0) rows = DIM_W'(1);
            else cols = DIM_W'(1);
        end
        rstep = pick_step();
        cstep = pick_step();
        mode  = ($urandom_range(0, 5) == 0) ? MODE_ZERO : MODE_BILINEAR;
        send_idle_on = !calm && $urandom_range(0, 3) != 0;
        recv_idle_on = !calm && $urandom_range(0, 3) != 0;
        apply_config(rows, cols, rstep, cstep, mode);
        load_image();
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 65)
                add_item(OP_REQUEST, PIX_W'($urandom), rand_target(rstep, eff_dim(rows)),
                         rand_target(cstep, eff_dim(cols)));
            else
                add_item(OP_LOAD, PIX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 1x1 image, unit steps
        add_item(OP_LOAD, 8'hFF, COORD_MAX, COORD_MAX);
        add_item(OP_REQUEST, 8'h00, 0, 0);
        add_item(OP_REQUEST, 8'hFF, COORD_MAX, COORD_MAX);
        add_item(OP_LOAD, 8'h00, 0, 0);
        add_item(OP_REQUEST, 8'h5A, 12'hA5A, 12'h5A5);
        wait_drained();

        // half steps on a 3x3 image, edges and far positions
        apply_config(3, 3, 24'h008000, 24'h008000, MODE_BILINEAR);
        for (int i = 0; i < 9; i++)
            add_item(OP_LOAD, (i % 3 == 0) ? 8'hFF : PIX_W'(i * 37), 0, 0);
        add_item(OP_REQUEST, 0, 0, 0);
        add_item(OP_REQUEST, 0, 1, 1);
        add_item(OP_REQUEST, 0, 2, 3);
        add_item(OP_REQUEST, 0, 5, 5);
        add_item(OP_REQUEST, 0, COORD_MAX, COORD_MAX);
        add_item(OP_REQUEST, 0, 0, COORD_MAX);
        add_item(OP_REQUEST, 0, COORD_MAX, 0);
        add_item(OP_REQUEST, 0, 3, 1);
        repeat (5) add_item(OP_LOAD, PIX_W'($urandom), 0, 0);
        wait_drained();

        // shrink below the load pointer; extreme steps
        apply_config(2, 2, '1, '0, MODE_BILINEAR);
        repeat (4) add_item(OP_LOAD, PIX_W'($urandom), 0, 0);
        add_item(OP_REQUEST, 0, 0, 0);
        add_item(OP_REQUEST, 0, 1, COORD_MAX);
        add_item(OP_REQUEST, 0, COORD_MAX, 1);
        add_item(OP_REQUEST, 0, 1, 1);
        wait_drained();

        apply_config(3, 3, 24'h010000, 24'h010000, MODE_ZERO);
        add_item(OP_REQUEST, 8'hFF, 1, 1);
        add_item(OP_REQUEST, 8'h00, 2, 2);
        wait_drained();

        // zero rows acts as one, oversized cols as the maximum
        apply_config(0, (1 << DIM_W) - 1, 24'h000100, 24'h00FF00, MODE_BILINEAR);
        load_image();
        repeat (20)
            add_item(OP_REQUEST, PIX_W'($urandom), rand_target(24'h000100, 1),
                     rand_target(24'h00FF00, MAX_DIM));
        wait_drained();

        for (int p = 0; p < 5; p++)
            random_phase(80, 1'b0);
        random_phase(160, 1'b1);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
src/bir_pkg.sv
src/bir_ram.sv
src/bir_fifo.sv
src/bir_front.sv
src/bir_back.sv
src/bilinear_image_resize.sv
bench/testbench.sv
